/* rtl/core/v3cdn_pkg.sv */
// Package for the three-component vector unit.
// Holds request/response structs, mode codes and widths; no dependencies.
package v3cdn_pkg;

  localparam int unsigned CompW = 16;   // Q8.8 component
  localparam int unsigned ResW  = 36;   // result field
  localparam int unsigned ProdW = 32;   // 16x16 signed product
  localparam int unsigned SumW  = 32;   // sum of three squares
  localparam int unsigned RootW = 16;   // floor sqrt of SumW bits
  localparam int unsigned RemW  = 18;   // sqrt partial remainder
  localparam int unsigned QuotW = 17;   // unit component magnitude, up to 65536

  localparam logic [1:0] ModeCross = 2'd0;
  localparam logic [1:0] ModeDot   = 2'd1;
  localparam logic [1:0] ModeNorm  = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [CompW-1:0] a_x;
    logic signed [CompW-1:0] a_y;
    logic signed [CompW-1:0] a_z;
    logic signed [CompW-1:0] b_x;
    logic signed [CompW-1:0] b_y;
    logic signed [CompW-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [ResW-1:0] r_x;
    logic signed [ResW-1:0] r_y;
    logic signed [ResW-1:0] r_z;
    logic                   status;
  } rsp_t;

  // Per-item side data that rides along the pipeline.
  typedef struct packed {
    logic [1:0]                  mode;
    logic [2:0]                  neg;
    logic [2:0][CompW-1:0]       mag;
    logic [2:0][ResW-1:0]        res;
  } side_t;

endpackage

/* rtl/core/vec3_cross_dot_normalize.sv */
// Top level of the three-component vector unit: cross, dot, normalize.
// Uses v3cdn_pkg for the request/response structs and constants.
//
// Usage
//   Input channel: in_valid_i / in_stall_o / in_req_i (mode, vectors a, b).
//   Output channel: out_valid_o / out_stall_i / out_rsp_o (r_x, r_y, r_z,
//   status). A request moves when valid is high and stall is low.
//   Mode 0: cross product a x b. Mode 1: dot product in r_x, r_y = r_z = 0.
//   Mode 2: a / |a| with each component scaled by 65536, truncated toward
//   zero; a zero vector gives zeros and status 1. Mode 3 gives all zeros.
// Pipeline and throughput
//   The path from acceptance to out_valid_o is one multiply stage, one
//   add stage, 16 square-root stages (one root bit each), 17 divide stages
//   (one quotient bit each, three lanes) and the output register.
//   One request per cycle is accepted while the output is not blocked; the
//   pipeline depth is set by the bit-per-stage square root and divide.
// Reset and stall
//   Reset clears all stage valid bits; the pipeline is empty afterwards.
//   When the output holds a result and out_stall_i is high the whole
//   pipeline freezes and in_stall_o rises; bubbles are not squeezed out.
module vec3_cross_dot_normalize (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  v3cdn_pkg::req_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output v3cdn_pkg::rsp_t   out_rsp_o
);

  localparam int unsigned CompW = v3cdn_pkg::CompW;
  localparam int unsigned ResW  = v3cdn_pkg::ResW;
  localparam int unsigned ProdW = v3cdn_pkg::ProdW;
  localparam int unsigned SumW  = v3cdn_pkg::SumW;
  localparam int unsigned RootW = v3cdn_pkg::RootW;
  localparam int unsigned RemW  = v3cdn_pkg::RemW;
  localparam int unsigned QuotW = v3cdn_pkg::QuotW;

  localparam int unsigned SqSt  = RootW;           // sqrt stages
  localparam int unsigned DvSt  = QuotW;           // divide stages
  localparam int unsigned SqBase = 2;              // side index feeding sqrt
  localparam int unsigned DvBase = SqBase + SqSt;  // side index feeding divide
  localparam int unsigned LastSt = DvBase + DvSt;  // last side index

  // Whole pipeline moves together unless the output is blocked.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic              vld_q  [1:LastSt];
  v3cdn_pkg::side_t  side_q [1:LastSt];

  // ---------------- stage 1: six multipliers, lanes 0..2 shared by the modes ----------------
  logic signed [CompW-1:0] op_a [0:5];
  logic signed [CompW-1:0] op_b [0:5];
  logic signed [ProdW-1:0] prod_q [0:5];

  always_comb begin
    // lanes 3..5 only matter for cross
    op_a[3] = in_req_i.a_z; op_b[3] = in_req_i.b_x;
    op_a[4] = in_req_i.a_x; op_b[4] = in_req_i.b_z;
    op_a[5] = in_req_i.a_x; op_b[5] = in_req_i.b_y;
    unique case (in_req_i.mode)
      v3cdn_pkg::ModeCross: begin
        op_a[0] = in_req_i.a_y; op_b[0] = in_req_i.b_z;
        op_a[1] = in_req_i.a_z; op_b[1] = in_req_i.b_y;
        op_a[2] = in_req_i.a_y; op_b[2] = in_req_i.b_x;
      end
      v3cdn_pkg::ModeNorm: begin
        op_a[0] = in_req_i.a_x; op_b[0] = in_req_i.a_x;
        op_a[1] = in_req_i.a_y; op_b[1] = in_req_i.a_y;
        op_a[2] = in_req_i.a_z; op_b[2] = in_req_i.a_z;
      end
      default: begin
        op_a[0] = in_req_i.a_x; op_b[0] = in_req_i.b_x;
        op_a[1] = in_req_i.a_y; op_b[1] = in_req_i.b_y;
        op_a[2] = in_req_i.a_z; op_b[2] = in_req_i.b_z;
      end
    endcase
  end

  v3cdn_pkg::side_t side_in;
  always_comb begin
    side_in.mode   = in_req_i.mode;
    side_in.neg    = {in_req_i.a_z[CompW-1], in_req_i.a_y[CompW-1], in_req_i.a_x[CompW-1]};
    side_in.mag[0] = in_req_i.a_x[CompW-1] ? CompW'(-in_req_i.a_x) : in_req_i.a_x;
    side_in.mag[1] = in_req_i.a_y[CompW-1] ? CompW'(-in_req_i.a_y) : in_req_i.a_y;
    side_in.mag[2] = in_req_i.a_z[CompW-1] ? CompW'(-in_req_i.a_z) : in_req_i.a_z;
    side_in.res    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        prod_q[i] <= op_a[i] * op_b[i];
      end
      side_q[1] <= side_in;
    end
  end

  // ---------------- stage 2: adds ----------------
  logic signed [ResW-1:0] px [0:5];
  logic [SumW-1:0]        sq_n_q    [0:SqSt];
  logic [RemW-1:0]        sq_rem_q  [0:SqSt];
  logic [RootW-1:0]       sq_root_q [0:SqSt];
  v3cdn_pkg::side_t       side_2;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      px[i] = ResW'(prod_q[i]);   // signed extension
    end
    side_2     = side_q[1];
    side_2.res = '0;
    unique case (side_q[1].mode)
      v3cdn_pkg::ModeCross: begin
        side_2.res[0] = px[0] - px[1];
        side_2.res[1] = px[3] - px[4];
        side_2.res[2] = px[5] - px[2];
      end
      v3cdn_pkg::ModeDot: begin
        side_2.res[0] = px[0] + px[1] + px[2];
      end
      default: begin
        side_2.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[2]    <= side_2;
      // squares are at most 2^30 each, so 31 bits carry them
      sq_n_q[0]    <= SumW'(prod_q[0][ProdW-2:0]) + SumW'(prod_q[1][ProdW-2:0])
                    + SumW'(prod_q[2][ProdW-2:0]);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  // ---------------- square root: one root bit per stage ----------------
  for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
    logic [RemW+1:0] rem_sh;
    logic [RemW+1:0] trial;
    logic            take;
    always_comb begin
      rem_sh = {sq_rem_q[k], sq_n_q[k][SumW-1 -: 2]};
      trial  = {2'b00, sq_root_q[k], 2'b01};
      take   = rem_sh >= trial;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_n_q[k+1]    <= sq_n_q[k] << 2;
        sq_rem_q[k+1]  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
        sq_root_q[k+1] <= {sq_root_q[k][RootW-2:0], take};
        side_q[SqBase+k+1] <= side_q[SqBase+k];
      end
    end
  end

  // ---------------- divide: three lanes, one quotient bit per stage ----------------
  logic [RootW-1:0] dv_len_q [0:DvSt];
  assign dv_len_q[0] = sq_root_q[SqSt];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [QuotW-1:0] rem_q  [0:DvSt];
    logic [QuotW-1:0] quot_q [0:DvSt];
    assign rem_q[0]  = QuotW'(side_q[DvBase].mag[l]);
    assign quot_q[0] = '0;
    for (genvar j = 0; j < DvSt; j++) begin : g_st
      logic [QuotW-1:0] rin;
      logic             ge;
      always_comb begin
        // the first step sees the magnitude itself, later steps shift in a zero
        rin = (j == 0) ? rem_q[j] : {rem_q[j][QuotW-2:0], 1'b0};
        ge  = rin >= QuotW'(dv_len_q[j]);
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[j+1]  <= ge ? rin - QuotW'(dv_len_q[j]) : rin;
          quot_q[j+1] <= {quot_q[j][QuotW-2:0], ge};
        end
      end
    end
  end

  for (genvar j = 0; j < DvSt; j++) begin : g_dvside
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_len_q[j+1]      <= dv_len_q[j];
        side_q[DvBase+j+1] <= side_q[DvBase+j];
      end
    end
  end

  // ---------------- output register ----------------
  v3cdn_pkg::rsp_t  rsp_d, rsp_q;
  logic             out_vld_q;
  logic [ResW-1:0]  unit [0:2];
  logic             len_zero;

  always_comb begin
    len_zero = dv_len_q[DvSt] == '0;
    unit[0] = side_q[LastSt].neg[0] ? -ResW'(g_lane[0].quot_q[DvSt])
                                     : ResW'(g_lane[0].quot_q[DvSt]);
    unit[1] = side_q[LastSt].neg[1] ? -ResW'(g_lane[1].quot_q[DvSt])
                                     : ResW'(g_lane[1].quot_q[DvSt]);
    unit[2] = side_q[LastSt].neg[2] ? -ResW'(g_lane[2].quot_q[DvSt])
                                     : ResW'(g_lane[2].quot_q[DvSt]);
    rsp_d = '0;
    unique case (side_q[LastSt].mode)
      v3cdn_pkg::ModeCross, v3cdn_pkg::ModeDot: begin
        rsp_d.r_x = side_q[LastSt].res[0];
        rsp_d.r_y = side_q[LastSt].res[1];
        rsp_d.r_z = side_q[LastSt].res[2];
      end
      v3cdn_pkg::ModeNorm: begin
        rsp_d.status = len_zero;
        if (!len_zero) begin
          rsp_d.r_x = unit[0];
          rsp_d.r_y = unit[1];
          rsp_d.r_z = unit[2];
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= LastSt; s++) begin
        vld_q[s] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= in_valid_i;
      for (int s = 2; s <= LastSt; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      out_vld_q <= vld_q[LastSt];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  // ---------------- assertions ----------------
  localparam logic [ResW-1:0] UnitMax = ResW'(65536);

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_status_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status) |->
      (out_rsp_o.r_x == '0 && out_rsp_o.r_y == '0 && out_rsp_o.r_z == '0))
    else $error("zero-length status with nonzero result");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_q[LastSt].mode == v3cdn_pkg::ModeNorm && !len_zero && adv)
      |=> ((out_rsp_o.r_x[ResW-1] ? -out_rsp_o.r_x : out_rsp_o.r_x) <= UnitMax))
    else $error("unit component above 65536");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q[LastSt]))
    else $error("pipeline moved while output blocked");

endmodule
